>>> src/pdm_pkg.sv
// Shared widths, configuration register codes and the multiplier request word
// for the derivative-on-measurement PID block. No dependencies.
package pdm_pkg;

    localparam int DATA_W    = 32;
    localparam int ERR_W     = DATA_W + 1;
    localparam int LIM_W     = DATA_W - 1;
    localparam int DT_W      = 16;
    localparam int FRAC_W    = 16;
    localparam int MUL_DIG_W = 4;
    localparam int MUL_STEPS = DATA_W / MUL_DIG_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int PROD_W    = ERR_W + DATA_W;
    localparam int DIV_W     = 2 * DATA_W;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 3;

    localparam logic [DT_W-1:0] DT_FLOOR = DT_W'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_OUT_LIMIT   = 3'd3,
        CFG_INTEG_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [ERR_W-1:0]  mcand;
        logic [DATA_W-1:0] mplier;
    } mul_req_t;

endpackage

>>> src/pdm_mul.sv
// Serial-parallel magnitude multiplier, one 4-bit multiplier digit per cycle.
// Depends on pdm_pkg.
module pdm_mul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pdm_pkg::mul_req_t        req,
    output logic                     done,
    output logic [pdm_pkg::PROD_W-1:0] prod
);
    import pdm_pkg::*;

    localparam int ACC_W = ERR_W + MUL_DIG_W;

    logic [ERR_W-1:0]     mcand_reg;
    logic [ERR_W-1:0]     hi_reg;
    logic [DATA_W-1:0]    lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [ACC_W-1:0]     acc;

    assign acc  = ACC_W'(hi_reg) + ACC_W'(mcand_reg) * ACC_W'(lo_reg[MUL_DIG_W-1:0]);
    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // shift the product right one digit per step
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg <= req.mcand;
            hi_reg    <= '0;
            lo_reg    <= req.mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= acc[ACC_W-1:MUL_DIG_W];
            lo_reg <= {acc[MUL_DIG_W-1:0], lo_reg[DATA_W-1:MUL_DIG_W]};
        end
    end

endmodule

>>> src/pdm_div.sv
// Restoring divider of a 64-bit magnitude by the 16-bit step time,
// two quotient bits per cycle. Depends on pdm_pkg.
module pdm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pdm_pkg::DIV_W-1:0] dividend,
    input  logic [pdm_pkg::DT_W-1:0]  divisor,
    output logic                      busy,
    output logic [pdm_pkg::DIV_W-1:0] quotient
);
    import pdm_pkg::*;

    logic [DT_W-1:0]      rem_reg;
    logic [DT_W-1:0]      dvs_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DT_W:0]        step_a;
    logic [DT_W:0]        step_b;

    // returns {quotient bit, new remainder}
    function automatic logic [DT_W:0] div_step(input logic [DT_W-1:0] rem,
                                               input logic            b_in,
                                               input logic [DT_W-1:0] dvs);
        logic [DT_W:0] t;
        logic [DT_W:0] d;
        t = {rem, b_in};
        d = {1'b0, dvs};
        if (t >= d)
            div_step = {1'b1, DT_W'(t - d)};
        else
            div_step = {1'b0, t[DT_W-1:0]};
    endfunction

    assign step_a   = div_step(rem_reg, quo_reg[DIV_W-1], dvs_reg);
    assign step_b   = div_step(step_a[DT_W-1:0], quo_reg[DIV_W-2], dvs_reg);
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= step_b[DT_W-1:0];
            quo_reg <= {quo_reg[DIV_W-3:0], step_a[DT_W], step_b[DT_W]};
        end
    end

endmodule

>>> src/pid_deriv_on_measurement_unit.sv
// Top level: PID controller in Q16.16 with derivative on measurement and
// integral clamp; sequencer, registers and output stage.
// Depends on pdm_pkg, pdm_mul and pdm_div.
//
// Usage
//   Input words (op, setpoint, measurement, step_time) enter on item_valid
//   while item_stall is low. One result word (drive) leaves per input word on
//   result_valid while result_stall is low. Registers are written on the cfg
//   channel (cfg_valid, cfg_ready always high, cfg_index, cfg_data) only while
//   the block is idle: a rule for the user that the block itself does not
//   enforce. Indexes beyond the register list are ignored. One word is worked
//   on at a time. The time per word is set by the first multiply on the
//   4-bit-digit shared multiplier followed by the divider, two quotient bits a
//   cycle, which runs alongside the other three multiplies. A clear word goes
//   straight to the output stage and gives 0.
//   The output register lets a new word be accepted while a result waits;
//   the sequencer holds a finished result until the output register is free.
//   Reset clears all configuration registers, the integral and the previous
//   measurement, and leaves result_valid low and item_stall low.
module pid_deriv_on_measurement_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic                              op,
    input  logic signed [pdm_pkg::DATA_W-1:0] setpoint,
    input  logic signed [pdm_pkg::DATA_W-1:0] measurement,
    input  logic [pdm_pkg::DT_W-1:0]          step_time,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [pdm_pkg::DATA_W-1:0] drive,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdm_pkg::DATA_W-1:0]        cfg_data
);
    import pdm_pkg::*;

    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int D_W    = DIV_W - 1;
    localparam int ISUM_W = ERR_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL_D,
        S_MUL_P,
        S_MUL_INC,
        S_CLAMP_I,
        S_START_I,
        S_MUL_I,
        S_WAIT_DIV,
        S_SUM,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic [LIM_W-1:0]         out_limit_reg;
    logic [LIM_W-1:0]         integ_limit_reg;

    logic signed [DATA_W-1:0] integ_acc_reg;
    logic signed [DATA_W-1:0] last_meas_reg;
    logic                     result_valid_reg;
    logic signed [DATA_W-1:0] drive_reg;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  dm_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [TERM_W-1:0] p_reg;
    logic signed [TERM_W-1:0] i_reg;
    logic signed [ERR_W-1:0]  incr_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [DIV_W-1:0]  sum_reg;

    logic                     accept;
    logic                     out_free;
    logic [DT_W-1:0]          dt_floored;
    logic [ERR_W-1:0]         err_mag;
    logic [ERR_W-1:0]         dm_mag;
    logic [DATA_W-1:0]        gp_mag;
    logic [DATA_W-1:0]        gi_mag;
    logic [DATA_W-1:0]        gd_mag;
    logic [DATA_W-1:0]        integ_mag;

    mul_req_t                 mul_req;
    logic                     mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic [TERM_W-1:0]        prod_hi;
    logic                     div_start;
    logic                     div_busy;
    logic [DIV_W-1:0]         div_quo;

    logic signed [TERM_W-1:0] p_val;
    logic signed [TERM_W-1:0] i_val;
    logic signed [ERR_W-1:0]  incr_val;
    logic signed [D_W-1:0]    d_val;
    logic [D_W-1:0]           d_mag;

    logic signed [ISUM_W-1:0] integ_sum;
    logic signed [ISUM_W-1:0] integ_lim;
    logic signed [DATA_W-1:0] integ_clamped;
    logic signed [DIV_W-1:0]  out_lim;
    logic signed [DATA_W-1:0] drive_clamped;

    function automatic logic [ERR_W-1:0] mag33(input logic [ERR_W-1:0] v);
        mag33 = v[ERR_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign result_valid = result_valid_reg;
    assign drive      = drive_reg;

    assign dt_floored = (step_time < DT_FLOOR) ? DT_FLOOR : step_time;

    assign err_mag   = mag33(err_reg);
    assign dm_mag    = mag33(dm_reg);
    assign gp_mag    = mag32(gain_p_reg);
    assign gi_mag    = mag32(gain_i_reg);
    assign gd_mag    = mag32(gain_d_reg);
    assign integ_mag = mag32(integ_acc_reg);

    assign prod_hi  = mul_prod[PROD_W-1:FRAC_W];
    assign p_val    = (gain_p_reg[DATA_W-1] ^ err_reg[ERR_W-1]) ? (~prod_hi + 1'b1) : prod_hi;
    assign i_val    = (gain_i_reg[DATA_W-1] ^ integ_acc_reg[DATA_W-1]) ?
                      (~prod_hi + 1'b1) : prod_hi;
    assign incr_val = err_reg[ERR_W-1] ? (~prod_hi[ERR_W-1:0] + 1'b1) : prod_hi[ERR_W-1:0];
    assign d_mag    = {1'b0, div_quo[D_W-2:0]};
    assign d_val    = (gain_d_reg[DATA_W-1] == dm_reg[ERR_W-1]) ? (~d_mag + 1'b1) : d_mag;

    assign integ_sum = {{(ISUM_W-DATA_W){integ_acc_reg[DATA_W-1]}}, integ_acc_reg}
                     + {incr_reg[ERR_W-1], incr_reg};
    assign integ_lim = {{(ISUM_W-LIM_W){1'b0}}, integ_limit_reg};
    assign out_lim   = {{(DIV_W-LIM_W){1'b0}}, out_limit_reg};

    always_comb
    begin
        priority if (integ_sum > integ_lim)
            integ_clamped = integ_lim[DATA_W-1:0];
        else if (integ_sum < -integ_lim)
            integ_clamped = DATA_W'(-integ_lim);
        else
            integ_clamped = integ_sum[DATA_W-1:0];
    end

    always_comb
    begin
        priority if (sum_reg > out_lim)
            drive_clamped = out_lim[DATA_W-1:0];
        else if (sum_reg < -out_lim)
            drive_clamped = DATA_W'(-out_lim);
        else
            drive_clamped = sum_reg[DATA_W-1:0];
    end

    // steer operands of the shared multiplier
    always_comb
    begin
        mul_req.start  = 1'b0;
        mul_req.mcand  = err_mag;
        mul_req.mplier = gp_mag;
        unique case (state_reg)
            S_LOAD:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = dm_mag;
                mul_req.mplier = gd_mag;
            end
            S_MUL_D:
            begin
                mul_req.start = mul_done;
            end
            S_MUL_P:
            begin
                mul_req.start  = mul_done;
                mul_req.mplier = DATA_W'(dt_reg);
            end
            S_START_I:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = ERR_W'(integ_mag);
                mul_req.mplier = gi_mag;
            end
            default:
            begin
            end
        endcase
    end

    assign div_start = (state_reg == S_MUL_D) && mul_done;

    pdm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pdm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod[DIV_W-1:0]),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = op ? S_FINISH : S_LOAD;
            end
            S_LOAD:     state_next = S_MUL_D;
            S_MUL_D:    if (mul_done) state_next = S_MUL_P;
            S_MUL_P:    if (mul_done) state_next = S_MUL_INC;
            S_MUL_INC:  if (mul_done) state_next = S_CLAMP_I;
            S_CLAMP_I:  state_next = S_START_I;
            S_START_I:  state_next = S_MUL_I;
            S_MUL_I:    if (mul_done) state_next = S_WAIT_DIV;
            S_WAIT_DIV: if (!div_busy) state_next = S_SUM;
            S_SUM:      state_next = S_FINISH;
            S_FINISH:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            drive_reg        <= '0;
            integ_acc_reg    <= '0;
            last_meas_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FINISH) && out_free)
            begin
                result_valid_reg <= 1'b1;
                drive_reg        <= drive_clamped;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                last_meas_reg <= op ? '0 : measurement;
                if (op)
                    integ_acc_reg <= '0;
            end
            else if (state_reg == S_CLAMP_I)
            begin
                integ_acc_reg <= integ_clamped;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg <= {setpoint[DATA_W-1], setpoint} - {measurement[DATA_W-1], measurement};
            dm_reg  <= {measurement[DATA_W-1], measurement}
                     - {last_meas_reg[DATA_W-1], last_meas_reg};
            dt_reg  <= dt_floored;
            if (op)
                sum_reg <= '0;
        end
        if ((state_reg == S_MUL_P) && mul_done)
            p_reg <= p_val;
        if ((state_reg == S_MUL_INC) && mul_done)
            incr_reg <= incr_val;
        if ((state_reg == S_MUL_I) && mul_done)
            i_reg <= i_val;
        if ((state_reg == S_WAIT_DIV) && !div_busy)
            d_reg <= d_val;
        if (state_reg == S_SUM)
            sum_reg <= {{(DIV_W-TERM_W){p_reg[TERM_W-1]}}, p_reg}
                     + {{(DIV_W-TERM_W){i_reg[TERM_W-1]}}, i_reg}
                     + {d_reg[D_W-1], d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            out_limit_reg   <= '0;
            integ_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                CFG_GAIN_I:      gain_i_reg      <= cfg_data;
                CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                CFG_OUT_LIMIT:   out_limit_reg   <= cfg_data[LIM_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> src/pdm_checker.sv
// Port-level checks for pid_deriv_on_measurement_unit and the bind that
// attaches them. Depends on pdm_pkg.
module pdm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_stall,
    input logic                       op,
    input logic                       result_valid,
    input logic                       result_stall,
    input logic [pdm_pkg::DATA_W-1:0] drive
);
    import pdm_pkg::*;

    // one word in flight: busy straight after an accepted word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input taken while a word is in flight");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(drive)))
        else $error("stalled result word dropped or changed");

    // a clear word into an empty output stage gives a zero result word
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && op && !result_valid)
            |-> ##2 (result_valid && (drive == DATA_W'(0))))
        else $error("clear word did not return zero");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result word appeared with no word in flight");

    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (!result_valid && !item_stall))
        else $error("block not idle after reset");

endmodule

bind pid_deriv_on_measurement_unit pdm_checker u_pdm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_deriv_on_measurement_unit: directed corner words, then
// random configurations and words under four idling phases, each result checked in order.
// Depends on pdm_pkg and the RTL of pid_deriv_on_measurement_unit.
module tb_top;

    import pdm_pkg::*;

    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] setpoint;
        logic signed [DATA_W-1:0] measurement;
        logic [DT_W-1:0]          step_time;
    } pid_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic                     op;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measurement;
    logic [DT_W-1:0]          step_time;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [DATA_W-1:0] drive;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;

    // controller copy: gains, limits and loop state
    longint kp;
    longint ki;
    longint kd;
    longint drive_lim;
    longint integ_lim;
    longint integ_sum;
    longint prev_meas;

    logic [DATA_W-1:0]        expected_drive[$];
    logic [DATA_W-1:0]        drive_want;
    logic signed [DATA_W-1:0] meas_track;
    int                       mismatch_count = 0;
    int                       send_idle_pct;
    int                       result_stall_pct;

    pid_deriv_on_measurement_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .setpoint     (setpoint),
        .measurement  (measurement),
        .step_time    (step_time),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .drive        (drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned magnitude_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint q16_product(longint a, longint b);
        longint unsigned m;
        m = (magnitude_of(a) * magnitude_of(b)) >> FRAC_W;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P:      kp = longint'($signed(data));
            CFG_GAIN_I:      ki = longint'($signed(data));
            CFG_GAIN_D:      kd = longint'($signed(data));
            CFG_OUT_LIMIT:   drive_lim = longint'(data[LIM_W-1:0]);
            CFG_INTEG_LIMIT: integ_lim = longint'(data[LIM_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] predict_drive(pid_word_t w);
        longint            err;
        longint            dm;
        longint            p_term;
        longint            i_term;
        longint            d_term;
        longint            total;
        longint unsigned   dt;
        longint unsigned   d_mag;
        if (w.op == OP_CLEAR)
        begin
            integ_sum = 0;
            prev_meas = 0;
            return '0;
        end
        dt = (w.step_time < DT_FLOOR) ? DT_FLOOR : w.step_time;
        err = longint'(w.setpoint) - longint'(w.measurement);
        p_term = q16_product(kp, err);
        integ_sum = clamp_to(integ_sum + q16_product(err, longint'(dt)), integ_lim);
        i_term = q16_product(ki, integ_sum);
        dm = longint'(w.measurement) - prev_meas;
        d_mag = (magnitude_of(kd) * magnitude_of(dm)) / dt;
        d_term = ((kd < 0) == (dm < 0)) ? -longint'(d_mag) : longint'(d_mag);
        total = clamp_to(p_term + i_term + d_term, drive_lim);
        prev_meas = longint'(w.measurement);
        return total[DATA_W-1:0];
    endfunction

    function automatic pid_word_t make_word(logic o, logic [DATA_W-1:0] sp,
                                            logic [DATA_W-1:0] meas, logic [DT_W-1:0] dt);
        pid_word_t w;
        w.op = o;
        w.setpoint = sp;
        w.measurement = meas;
        w.step_time = dt;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] edge_value();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_gain();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return edge_value();
            default: return $signed($urandom) >>> $urandom_range(31, 12);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] draw_limit();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return '0;
            default: return $urandom >> $urandom_range(31, 8);
        endcase
    endfunction

    function automatic pid_word_t random_word();
        pid_word_t w;
        w.op = ($urandom_range(99) < 6) ? OP_CLEAR : OP_COMPUTE;
        case ($urandom_range(3))
            0:       w.measurement = $urandom;
            1:       w.measurement = edge_value();
            default: w.measurement = meas_track + ($signed($urandom) >>> $urandom_range(31, 10));
        endcase
        case ($urandom_range(3))
            0:       w.setpoint = $urandom;
            1:       w.setpoint = edge_value();
            default: w.setpoint = w.measurement + ($signed($urandom) >>> $urandom_range(31, 8));
        endcase
        case ($urandom_range(4))
            0:       w.step_time = DT_W'($urandom_range(6));
            1:       w.step_time = DT_W'($urandom_range(400, 7));
            2:       w.step_time = '1;
            default: w.step_time = DT_W'($urandom);
        endcase
        if (w.op == OP_COMPUTE)
            meas_track = w.measurement;
        return w;
    endfunction

    task automatic send_word(input pid_word_t w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid  <= 1'b1;
        op          <= w.op;
        setpoint    <= w.setpoint;
        measurement <= w.measurement;
        step_time   <= w.step_time;
        do
            @(posedge clk);
        while (item_stall);
        expected_drive.push_back(predict_drive(w));
    endtask

    // drop valid and hold until every outstanding word has come back
    task automatic drain();
        item_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
                              input logic [DATA_W-1:0] gd, input logic [DATA_W-1:0] ol,
                              input logic [DATA_W-1:0] il);
        drain();
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_OUT_LIMIT, ol);
        write_reg(CFG_INTEG_LIMIT, il);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int count);
        int left;
        int seg;
        send_idle_pct = idle_pct;
        result_stall_pct = stall_pct;
        left = count;
        while (left > 0)
        begin
            set_config(draw_gain(), draw_gain(), draw_gain(), draw_limit(), draw_limit());
            seg = $urandom_range(90, 30);
            for (int k = 0; k < seg && left > 0; k++)
            begin
                send_word(random_word());
                left--;
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_word(make_word(OP_COMPUTE, 32'h7fff_ffff, 32'h8000_0000, 16'h0000));
        send_word(make_word(OP_COMPUTE, $urandom, $urandom, DT_W'($urandom)));
    endtask

    task automatic test_directed_cases();
        set_config(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(make_word(OP_COMPUTE, 32'h7fff_ffff, 32'h8000_0000, 16'hffff));
        send_word(make_word(OP_COMPUTE, 32'h8000_0000, 32'h7fff_ffff, 16'h0000));
        send_word(make_word(OP_COMPUTE, 32'h0000_0000, 32'h0001_0000, 16'h0006));
        send_word(make_word(OP_COMPUTE, 32'h0000_0000, 32'h0003_0000, 16'h0007));
        send_word(make_word(OP_CLEAR, $urandom, $urandom, DT_W'($urandom)));
        send_word(make_word(OP_COMPUTE, 32'h0010_0000, 32'h0000_0000, 16'h0100));
        // top bit of each limit word must be dropped
        set_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8001_0000, 32'hffff_8000);
        send_word(make_word(OP_COMPUTE, 32'h7fff_ffff, 32'h0000_0000, 16'hffff));
        send_word(make_word(OP_COMPUTE, 32'h8000_0000, 32'h0000_0001, 16'h0001));
        send_word(make_word(OP_COMPUTE, 32'h0000_0002, 32'h0000_0002, 16'h8000));
        send_word(make_word(OP_COMPUTE, 32'hffff_ffff, 32'h8000_0000, 16'h0000));
        set_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
        send_word(make_word(OP_COMPUTE, 32'h8000_0000, 32'h7fff_ffff, 16'h0003));
        send_word(make_word(OP_COMPUTE, 32'h7fff_ffff, 32'h8000_0000, 16'hffff));
    endtask

    task automatic test_ignored_index();
        set_config(32'h0002_0000, 32'hffff_0000, 32'h0000_4000, 32'h7fff_ffff, 32'h0100_0000);
        for (int idx = int'(CFG_INTEG_LIMIT) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), $urandom);
        cfg_valid <= 1'b0;
        send_word(make_word(OP_COMPUTE, 32'h0005_0000, 32'h0001_0000, 16'h0200));
        send_word(make_word(OP_COMPUTE, 32'hfffb_0000, 32'h0002_8000, 16'h0040));
        send_word(make_word(OP_COMPUTE, 32'h0000_0000, 32'hffff_0000, 16'h0002));
    endtask

    task automatic test_random_no_idle();
        run_random(0, 0, 480);
    endtask

    task automatic test_random_sender_idle();
        run_random(76, 0, 480);
    endtask

    task automatic test_random_receiver_stall();
        run_random(0, 76, 480);
    endtask

    task automatic test_random_both_idle();
        run_random(29, 29, 480);
    endtask

    always @(posedge clk)
    begin
        result_stall <= (result_stall_pct != 0) && ($urandom_range(99) < result_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_drive.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected drive word: expected none, got 0x%08h", $time, drive);
            end
            else
            begin
                drive_want = expected_drive.pop_front();
                if (drive !== drive_want)
                begin
                    mismatch_count++;
                    $display("%0t: drive mismatch: expected 0x%08h (%0d), got 0x%08h (%0d)",
                             $time, drive_want, $signed(drive_want), drive, drive);
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        item_valid       = 1'b0;
        op               = OP_COMPUTE;
        setpoint         = '0;
        measurement      = '0;
        step_time        = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_GAIN_P;
        cfg_data         = '0;
        kp               = 0;
        ki               = 0;
        kd               = 0;
        drive_lim        = 0;
        integ_lim        = 0;
        integ_sum        = 0;
        prev_meas        = 0;
        meas_track       = '0;
        send_idle_pct    = 0;
        result_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_ignored_index();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        drain();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && expected_drive.size() == 0)
            $display("[pid_deriv_on_measurement_unit] OK");
        else
            $display("[pid_deriv_on_measurement_unit] ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("[pid_deriv_on_measurement_unit] ERROR");
        $finish;
    end

endmodule
